>>> rtl/sbus_frame_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// sbus frame decoder assertion macros
// Concurrent assertion helpers shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_DECODER_CORE_ASSERT_SVH
`define SBUS_FRAME_DECODER_CORE_ASSERT_SVH

`ifndef SYNTH

// implication or plain property, checked out of reset
`define SFD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// condition that must never be seen out of reset
`define SFD_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error(msg);

`else

`define SFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFD_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sbus frame decoder package
// Word types, frame constants and the front/back link types.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int CHAN_W      = 11;
	localparam int CHAN_IDX_W  = 4;
	localparam int BANK_W      = 1;
	localparam int MEM_ADDR_W  = BANK_W + CHAN_IDX_W;
	localparam int NUM_BANKS   = 2;
	localparam int TOKEN_DEPTH = NUM_BANKS;

	localparam logic [7:0] HEADER_BYTE = 8'h0F;
	localparam logic [7:0] FOOTER_BYTE = 8'h00;

	localparam logic [4:0] LAST_DATA_POS = 5'd22;
	localparam logic [4:0] FLAG_POS      = 5'd23;
	localparam logic [4:0] FINAL_POS     = 5'd24;

	localparam logic [CHAN_IDX_W-1:0] LAST_CHANNEL = 4'd15;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		logic [CHAN_IDX_W-1:0] channel_index;
		logic [CHAN_W-1:0]     channel_value;
		logic                  last;
	} out_word_t;

	typedef enum logic [2:0] {
		KIND_IDLE,
		KIND_START,
		KIND_DATA,
		KIND_FLAG,
		KIND_FINAL
	} byte_kind_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef struct packed {
		logic                  en;
		logic [MEM_ADDR_W-1:0] addr;
		logic [CHAN_W-1:0]     data;
	} mem_wr_t;

	typedef struct packed {
		logic              valid;
		logic [BANK_W-1:0] bank;
	} bank_done_t;

endpackage

>>> rtl/sfd_front.sv
// ----------------------------------------------------------------------------
// sbus frame decoder front end
// Classifies frame bytes, unpacks the 11-bit channel stream into the
// channel store bank in use and hands finished good frames to the back end.
// ----------------------------------------------------------------------------
module sfd_front
	import sfd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  in_word_t               rx,
	output mem_wr_t                mem_wr,
	output logic                   tok_push,
	output logic [BANK_W-1:0]      tok_bank,
	input  logic                   tok_full,
	input  bank_done_t             done
);

	`include "sbus_frame_decoder_core_assert.svh"

	logic [4:0]            pos_q, pos_d;
	logic                  hdr_ok_q, hdr_ok_d;
	logic [9:0]            buf_q, buf_d;
	logic [3:0]            held_q, held_d;
	logic [CHAN_IDX_W-1:0] ch_q, ch_d;
	logic [BANK_W-1:0]     wr_bank_q;
	logic [NUM_BANKS-1:0]  busy_q, busy_d;

	logic                  accept;
	byte_kind_t            kind;
	logic [17:0]           merged;
	logic [4:0]            held_sum;
	logic [4:0]            held_left;
	logic                  spill;
	logic                  good_end;

	assign full   = busy_q[wr_bank_q] | tok_full;
	assign accept = push & ~full;

	always_comb begin
		if (rx.frame_start) begin
			kind = KIND_START;
		end else begin
			case (pos_q) inside
				5'd0:                   kind = KIND_IDLE;
				[5'd1:LAST_DATA_POS]:   kind = KIND_DATA;
				FLAG_POS:               kind = KIND_FLAG;
				FINAL_POS:              kind = KIND_FINAL;
				default:                kind = KIND_IDLE;
			endcase
		end
	end

	// bit stream unpacker, lsb first
	assign merged    = {8'b0, buf_q} | ({10'b0, rx.rx_byte} << held_q);
	assign held_sum  = {1'b0, held_q} + 5'd8;
	assign held_left = held_sum - 5'd11;
	assign spill     = held_sum >= 5'd11;

	assign good_end = accept && (kind == KIND_FINAL) && hdr_ok_q
		&& (rx.rx_byte == FOOTER_BYTE);

	always_comb begin
		pos_d         = pos_q;
		hdr_ok_d      = hdr_ok_q;
		buf_d         = buf_q;
		held_d        = held_q;
		ch_d          = ch_q;
		mem_wr.en     = 1'b0;
		mem_wr.addr   = {wr_bank_q, ch_q};
		mem_wr.data   = merged[CHAN_W-1:0];
		if (accept) begin
			case (kind)
				KIND_START: begin
					hdr_ok_d = (rx.rx_byte == HEADER_BYTE);
					pos_d    = 5'd1;
					buf_d    = '0;
					held_d   = '0;
					ch_d     = '0;
				end
				KIND_DATA: begin
					pos_d = pos_q + 5'd1;
					if (spill) begin
						mem_wr.en = 1'b1;
						buf_d     = {3'b0, merged[17:11]};
						held_d    = held_left[3:0];
						ch_d      = ch_q + 4'd1;
					end else begin
						buf_d  = merged[9:0];
						held_d = held_sum[3:0];
					end
				end
				KIND_FLAG: begin
					pos_d = pos_q + 5'd1;
				end
				KIND_FINAL: begin
					pos_d = 5'd0;
				end
				default: begin
				end
			endcase
		end
	end

	assign tok_push = good_end;
	assign tok_bank = wr_bank_q;

	always_comb begin
		busy_d = busy_q;
		if (done.valid) begin
			busy_d[done.bank] = 1'b0;
		end
		if (good_end) begin
			busy_d[wr_bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hdr_ok_q  <= 1'b0;
			buf_q     <= '0;
			held_q    <= '0;
			ch_q      <= '0;
			wr_bank_q <= '0;
			busy_q    <= '0;
		end else begin
			pos_q    <= pos_d;
			hdr_ok_q <= hdr_ok_d;
			buf_q    <= buf_d;
			held_q   <= held_d;
			ch_q     <= ch_d;
			busy_q   <= busy_d;
			if (good_end) begin
				wr_bank_q <= wr_bank_q + 1'b1;
			end
		end
	end

	`SFD_ASSERT(a_wr_free_bank, clk, arst_n, mem_wr.en |-> !busy_q[mem_wr.addr[MEM_ADDR_W-1]], "store write into a bank awaiting readout")
	`SFD_NEVER(a_tok_overflow, clk, arst_n, tok_push && tok_full, "frame token pushed into a full queue")

endmodule

>>> rtl/sfd_token_fifo.sv
// ----------------------------------------------------------------------------
// sbus frame decoder token queue
// Short queue of finished frame banks between front end and back end.
// ----------------------------------------------------------------------------
module sfd_token_fifo
	import sfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [BANK_W-1:0] wr_bank,
	output logic              tok_full,
	input  logic              rd_en,
	output logic [BANK_W-1:0] rd_bank,
	output logic              tok_empty
);

	`include "sbus_frame_decoder_core_assert.svh"

	localparam int PTR_W = (TOKEN_DEPTH > 1) ? $clog2(TOKEN_DEPTH) : 1;
	localparam int CNT_W = $clog2(TOKEN_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TOKEN_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TOKEN_DEPTH);

	logic [BANK_W-1:0] slot_q [TOKEN_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              do_wr;
	logic              do_rd;

	assign tok_full  = (cnt_q == CNT_FULL);
	assign tok_empty = (cnt_q == '0);
	assign rd_bank   = slot_q[rd_ptr_q];
	assign do_wr     = wr_en & ~tok_full;
	assign do_rd     = rd_en & ~tok_empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_bank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`SFD_NEVER(a_tok_underflow, clk, arst_n, rd_en && tok_empty, "token read from an empty queue")

endmodule

>>> rtl/sfd_back.sv
// ----------------------------------------------------------------------------
// sbus frame decoder back end
// Holds the two-bank channel store and reads a finished frame out as
// sixteen channel words through a registered result stage.
// ----------------------------------------------------------------------------
module sfd_back
	import sfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mem_wr_t           mem_wr,
	output logic              tok_pop,
	input  logic [BANK_W-1:0] tok_bank,
	input  logic              tok_empty,
	output logic              empty,
	input  logic              pop,
	output out_word_t         result,
	output bank_done_t        done
);

	`include "sbus_frame_decoder_core_assert.svh"

	localparam int MEM_DEPTH = 1 << MEM_ADDR_W;

	logic [CHAN_W-1:0]     mem_q [MEM_DEPTH];

	seq_state_t            state_q, state_d;
	logic [BANK_W-1:0]     bank_q;
	logic [CHAN_IDX_W-1:0] ch_q;

	logic                  valid_s1;
	logic [CHAN_IDX_W-1:0] idx_s1;
	logic [BANK_W-1:0]     bank_s1;
	logic [CHAN_W-1:0]     rd_data_s1;

	logic                  out_valid_q;
	out_word_t             out_q;
	logic [BANK_W-1:0]     out_bank_q;

	logic                  issue;
	logic                  out_ready;
	logic                  move_s1;

	assign out_ready = ~out_valid_q | pop;
	assign move_s1   = valid_s1 & out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (!tok_empty) begin
					state_d = SEQ_RUN;
				end
			end
			SEQ_RUN: begin
				if (issue && (ch_q == LAST_CHANNEL)) begin
					state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		tok_pop = 1'b0;
		issue   = 1'b0;
		case (state_q)
			SEQ_IDLE: tok_pop = ~tok_empty;
			SEQ_RUN:  issue   = ~valid_s1 | move_s1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem_q[mem_wr.addr] <= mem_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem_q[{bank_q, ch_q}];
			idx_s1     <= ch_q;
			bank_s1    <= bank_q;
		end
		if (move_s1) begin
			out_q.channel_index <= idx_s1;
			out_q.channel_value <= rd_data_s1;
			out_q.last          <= (idx_s1 == LAST_CHANNEL);
			out_bank_q          <= bank_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			bank_q      <= '0;
			ch_q        <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tok_pop) begin
				bank_q <= tok_bank;
				ch_q   <= '0;
			end else if (issue) begin
				ch_q <= ch_q + 1'b1;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty      = ~out_valid_q;
	assign result     = out_q;
	assign done.valid = out_valid_q & pop & out_q.last;
	assign done.bank  = out_bank_q;

	`SFD_ASSERT(a_issue_in_run, clk, arst_n, issue |-> (state_q == SEQ_RUN), "store read issued outside a readout")
	`SFD_ASSERT(a_s1_hold, clk, arst_n, (valid_s1 && !out_ready) |=> (valid_s1 && $stable(rd_data_s1)), "stalled read data lost")
	`SFD_ASSERT(a_done_bank, clk, arst_n, done.valid |-> (out_q.channel_index == LAST_CHANNEL), "bank released before its last channel")

endmodule

>>> rtl/sbus_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// sbus frame decoder core
// Decodes 25-byte radio-control serial frames into sixteen 11-bit channels.
//
// channel   direction  handshake           word
// rx        in         push / full         rx_byte, frame_start
// result    out        pop / empty         channel_index, channel_value, last
//
// the front end takes one byte per cycle while full is low; a good frame's
// sixteen channels follow its footer, one per cycle while pop stays high
// full rises only while both store banks hold frames not yet read out
// reset clears all control state at once; the store needs no clearing pass
// ----------------------------------------------------------------------------
module sbus_frame_decoder_core
	import sfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  rx,
	output logic      empty,
	input  logic      pop,
	output out_word_t result
);

	mem_wr_t           mem_wr;
	logic              tok_push;
	logic [BANK_W-1:0] tok_wr_bank;
	logic              tok_full;
	logic              tok_pop;
	logic [BANK_W-1:0] tok_rd_bank;
	logic              tok_empty;
	bank_done_t        done;

	sfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.rx       (rx),
		.mem_wr   (mem_wr),
		.tok_push (tok_push),
		.tok_bank (tok_wr_bank),
		.tok_full (tok_full),
		.done     (done)
	);

	sfd_token_fifo u_tok (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (tok_push),
		.wr_bank   (tok_wr_bank),
		.tok_full  (tok_full),
		.rd_en     (tok_pop),
		.rd_bank   (tok_rd_bank),
		.tok_empty (tok_empty)
	);

	sfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_wr    (mem_wr),
		.tok_pop   (tok_pop),
		.tok_bank  (tok_rd_bank),
		.tok_empty (tok_empty),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.done      (done)
	);

endmodule

>>> verif/sbus_channel_checker.sv
// ----------------------------------------------------------------------------
// sbus channel checker
// Watches the byte and channel ports of the frame decoder, rebuilds each
// frame's sixteen channels from the accepted bytes and compares every
// channel word that leaves the decoder against the oldest one predicted.
// ----------------------------------------------------------------------------
module sbus_channel_checker
	import sfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic      full,
	input  in_word_t  rx,
	input  logic      empty,
	input  logic      pop,
	input  out_word_t result,
	output int        mismatches,
	output int        outstanding,
	output int        words_checked
);

	logic [4:0]        byte_pos;
	logic              hdr_ok;
	logic [17:0]       stream_bits;
	logic [4:0]        bits_held;
	logic [3:0]        next_chan;
	logic [CHAN_W-1:0] chan_store [16];
	out_word_t         want_channels [$];

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic decode_byte(input in_word_t w);
		logic [17:0] merged;
		out_word_t   word;
		if (w.frame_start) begin
			hdr_ok      = (w.rx_byte == HEADER_BYTE);
			byte_pos    = 5'd1;
			stream_bits = '0;
			bits_held   = '0;
			next_chan   = '0;
		end else if (byte_pos == 5'd0) begin
			// idle, byte dropped
		end else if (byte_pos <= LAST_DATA_POS) begin
			merged = stream_bits | ({10'd0, w.rx_byte} << bits_held);
			bits_held += 5'd8;
			if (bits_held >= 5'd11) begin
				chan_store[next_chan] = merged[CHAN_W-1:0];
				merged = merged >> CHAN_W;
				bits_held -= 5'd11;
				next_chan++;
			end
			stream_bits = merged;
			byte_pos++;
		end else if (byte_pos < FINAL_POS) begin
			byte_pos++;
		end else begin
			byte_pos = 5'd0;
			if (hdr_ok && w.rx_byte == FOOTER_BYTE) begin
				for (int k = 0; k < 16; k++) begin
					word.channel_index = CHAN_IDX_W'(k);
					word.channel_value = chan_store[k];
					word.last          = (CHAN_IDX_W'(k) == LAST_CHANNEL);
					want_channels.push_back(word);
				end
			end
		end
	endtask

	task automatic check_channel(input out_word_t got);
		out_word_t want;
		if (want_channels.size() == 0) begin
			report($sformatf("unexpected word idx %0d val %0d last %0d",
				got.channel_index, got.channel_value, got.last));
		end else begin
			want = want_channels.pop_front();
			if (got.channel_index !== want.channel_index)
				report($sformatf("channel_index got %0d want %0d",
					got.channel_index, want.channel_index));
			if (got.channel_value !== want.channel_value)
				report($sformatf("channel %0d value got %0d want %0d",
					want.channel_index, got.channel_value, want.channel_value));
			if (got.last !== want.last)
				report($sformatf("channel %0d last got %0d want %0d",
					want.channel_index, got.last, want.last));
			words_checked++;
		end
	endtask

	initial begin
		mismatches    = 0;
		words_checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos    = '0;
			hdr_ok      = 1'b0;
			stream_bits = '0;
			bits_held   = '0;
			next_chan   = '0;
			want_channels.delete();
			outstanding <= 0;
		end else begin
			if (push && !full)
				decode_byte(rx);
			if (pop && !empty)
				check_channel(result);
			outstanding <= want_channels.size();
		end
	end

endmodule

>>> verif/tb_sbus_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// sbus frame decoder core testbench
// Feeds whole, cut-short and corrupted frames plus stray bytes into the
// decoder with random gaps on both sides; a checker beside the decoder
// predicts the channel words and counts every mismatch.
// ----------------------------------------------------------------------------
module tb_sbus_frame_decoder_core;
	import sfd_pkg::*;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES,
		FILL_EXTREME
	} fill_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_word_t  rx;
	logic      empty;
	logic      pop;
	out_word_t result;

	int mismatches;
	int outstanding;
	int words_checked;
	int items;
	int frames;
	int good_frames;
	bit rx_burst;
	bit pop_burst;

	sbus_frame_decoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.rx     (rx),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	sbus_channel_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rx            (rx),
		.empty         (empty),
		.pop           (pop),
		.result        (result),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.words_checked (words_checked)
	);

	always #1 clk = ~clk;

	task automatic send_byte(input logic [7:0] b, input logic start);
		int gap;
		if ($urandom_range(0, 31) == 0)
			rx_burst = !rx_burst;
		gap = rx_burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx   <= '{rx_byte: b, frame_start: start};
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic drain_results;
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [7:0] fill_byte(input fill_t f);
		case (f)
			FILL_ZERO:    return 8'h00;
			FILL_ONES:    return 8'hFF;
			FILL_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default:      return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_frame(input logic [7:0] hdr, input logic [7:0] footer,
			input fill_t f, input int len);
		send_byte(hdr, 1'b1);
		for (int pos = 1; pos < len; pos++) begin
			if (pos <= LAST_DATA_POS)
				send_byte(fill_byte(f), 1'b0);
			else if (pos == FLAG_POS)
				send_byte(8'($urandom_range(0, 255)), 1'b0);
			else
				send_byte(footer, 1'b0);
		end
		items += len;
		frames++;
		if (len == FINAL_POS + 1 && hdr == HEADER_BYTE && footer == FOOTER_BYTE)
			good_frames++;
	endtask

	// result side
	initial begin
		int stall;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0)
				pop_burst = !pop_burst;
			stall = pop_burst ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin
		int          pick;
		int          len;
		fill_t       f;
		logic [7:0]  hdr;
		logic [7:0]  footer;
		push        = 1'b0;
		rx          = '0;
		arst_n      = 1'b0;
		rx_burst    = 1'b0;
		pop_burst   = 1'b0;
		items       = 0;
		frames      = 0;
		good_frames = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray bytes while idle, a frame cut short by a new start, then all ones
		send_byte(8'hA5, 1'b0);
		send_byte(HEADER_BYTE, 1'b0);
		send_frame(HEADER_BYTE, FOOTER_BYTE, FILL_RANDOM, 4);
		send_frame(HEADER_BYTE, FOOTER_BYTE, FILL_ONES, FINAL_POS + 1);
		drain_results;

		while (items < 280) begin
			pick   = $urandom_range(0, 99);
			hdr    = (pick < 12) ? 8'($urandom_range(0, 255)) : HEADER_BYTE;
			footer = (pick >= 12 && pick < 24) ? 8'($urandom_range(1, 255)) : FOOTER_BYTE;
			len    = (pick >= 24 && pick < 34) ? $urandom_range(1, FINAL_POS)
				: FINAL_POS + 1;
			pick   = $urandom_range(0, 7);
			f      = (pick < 5) ? FILL_RANDOM : fill_t'(pick - 4);
			send_frame(hdr, footer, f, len);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
			if ($urandom_range(0, 15) == 0)
				drain_results;
		end

		drain_results;
		repeat (20) @(posedge clk);
		$display("sent %0d frame bytes in %0d frames, %0d of them good", items, frames,
			good_frames);
		$display("checked %0d channel words, %0d mismatches", words_checked, mismatches);
		if (mismatches == 0)
			$display("tb_sbus_frame_decoder_core passed");
		else
			$display("tb_sbus_frame_decoder_core failed");
		$finish;
	end

	initial begin
		#400000;
		$display("timeout with %0d channel words still expected", outstanding);
		$display("tb_sbus_frame_decoder_core failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_front.sv
rtl/sfd_token_fifo.sv
rtl/sfd_back.sv
rtl/sbus_frame_decoder_core.sv
verif/sbus_channel_checker.sv
verif/tb_sbus_frame_decoder_core.sv
